// ===== rtl/core/tdpt_pkg.sv =====
// Shared types and constants for the trial division prime test block.
// Used by tdpt_rem_unit and trial_division_prime_test; depends on nothing.
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIRST_DIVISOR   = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
    } t_rem_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_rem_stat;

endpackage

`default_nettype wire

// ===== rtl/core/trial_division_prime_test.sv =====
// Top level of the trial division prime test: sequencer, divisor and square
// tracking, and output register. Depends on tdpt_pkg and tdpt_rem_unit.
//
// A request on the slave side carries one unsigned candidate in s_tdata. The
// block tries divisors d = 2, 3, ... while d*d does not exceed the candidate,
// taking the remainder of each with the shared bit-serial remainder unit.
// A zero remainder ends the search as composite; candidates below two are
// never prime. The result request on the master side carries the candidate
// echoed back and the is_prime flag.
// Each divisor is worked by the remainder unit, which retires one dividend
// bit per cycle. A 16-bit prime near the top of the range tries 254
// divisors. One candidate is in work at a time, s_tready is low while the
// search runs, and it rises in the cycle after the result is loaded. The
// result sits in an output register, so a new candidate is taken while the
// previous result waits for m_tready; if the receiver still stalls when the
// next search ends, the sequencer holds its result.
// Reset empties the output register and returns the sequencer to idle.
`default_nettype none

module trial_division_prime_test #(
    parameter  int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF,
    localparam int IN_W        = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W       = ((VALUE_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // Fields from bit 0: candidate.
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // Fields from bit 0: tested_value, is_prime.
    output logic [OUT_W-1:0]      o_m_tdata
);
    import tdpt_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [VALUE_WIDTH-1:0] n_d;
    logic [VALUE_WIDTH:0]   r_sq;
    logic [VALUE_WIDTH:0]   n_sq;
    logic                   r_prime;
    logic                   n_prime;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_prime;

    logic                   w_accept;
    logic                   w_load_out;
    logic                   w_small;
    logic                   w_past_root;
    t_rem_ctrl              w_rem_ctrl;
    t_rem_stat              w_rem_stat;

    tdpt_rem_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_rem_ctrl),
        .i_dividend(r_n),
        .i_divisor (r_d),
        .o_stat    (w_rem_stat)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_small     = (r_n < VALUE_WIDTH'(FIRST_DIVISOR));
    assign w_past_root = (r_sq > {1'b0, r_n});
    assign w_load_out  = (r_state == S_FINISH) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_small || w_past_root) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rem_stat.done) begin
                    n_state = w_rem_stat.rem_zero ? S_FINISH : S_CHECK;
                end
            end
            S_FINISH: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_d              = r_d;
        n_sq             = r_sq;
        n_prime          = r_prime;
        w_rem_ctrl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_d  = VALUE_WIDTH'(FIRST_DIVISOR);
                n_sq = (VALUE_WIDTH + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
            end
            S_CHECK: begin
                if (w_small) begin
                    n_prime = 1'b0;
                end else if (w_past_root) begin
                    n_prime = 1'b1;
                end else begin
                    w_rem_ctrl.start = 1'b1;
                end
            end
            S_DIV: begin
                if (w_rem_stat.done) begin
                    n_prime = 1'b0;
                    n_d     = r_d + 1'b1;
                    n_sq    = r_sq + {r_d, 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_prime <= n_prime;
        if (w_accept) begin
            r_n <= i_s_tdata[VALUE_WIDTH-1:0];
        end
        if (w_load_out) begin
            r_out_value <= r_n;
            r_out_prime <= r_prime;
        end
    end

    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata                  = '0;
        o_m_tdata[VALUE_WIDTH-1:0] = r_out_value;
        o_m_tdata[VALUE_WIDTH]     = r_out_prime;
    end

    a_start_at_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_d == VALUE_WIDTH'(FIRST_DIVISOR)))
        else $error("Search did not start at the first divisor.");

    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |->
            ((2 * VALUE_WIDTH)'(r_sq) == (2 * VALUE_WIDTH)'(r_d) * (2 * VALUE_WIDTH)'(r_d)))
        else $error("Running square differs from divisor squared.");

    a_div_has_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_rem_stat.busy || w_rem_stat.done))
        else $error("Waiting on a remainder unit that is idle.");

    a_small_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_value < VALUE_WIDTH'(FIRST_DIVISOR))) |-> !r_out_prime)
        else $error("Value below two reported as prime.");

endmodule

`default_nettype wire

// ===== rtl/core/tdpt_rem_unit.sv =====
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// Depends on tdpt_pkg for its control and status structs.
`default_nettype none

module tdpt_rem_unit #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tdpt_pkg::t_rem_ctrl    i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [VALUE_WIDTH-1:0] i_divisor,
    output tdpt_pkg::t_rem_stat         o_stat
);
    import tdpt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [VALUE_WIDTH:0]   w_shift;
    logic [VALUE_WIDTH+1:0] w_diff;
    logic [VALUE_WIDTH-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[VALUE_WIDTH-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, i_divisor};
        if (w_diff[VALUE_WIDTH+1]) begin
            n_rem = w_shift[VALUE_WIDTH-1:0];
        end else begin
            n_rem = w_diff[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

// ===== dv/tb_trial_division_prime_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for trial_division_prime_test: stream requests of candidates
// in, compare each result against an in-bench trial-division predictor. Depends on tdpt_pkg.
module tb_trial_division_prime_test;

    localparam int VW             = tdpt_pkg::VALUE_WIDTH_DEF;
    localparam int IN_W           = ((VW + 7) / 8) * 8;
    localparam int OUT_W          = ((VW + 1 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT    = 10_000_000;
    localparam int TAIL_CYCLES    = 5000;
    localparam int RX_HOLD_CYCLES = 3000;

    typedef struct {
        logic [VW-1:0] value;
        logic          prime;
    } t_prime_verdict;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tready = 1'b0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;

    logic [VW-1:0]    cand_queue[$];
    t_prime_verdict   verdict_queue[$];
    t_prime_verdict   oldest;
    logic             req_taken = 1'b0;
    logic             calm = 1'b0;
    logic             rx_hold_req = 1'b0;
    logic             rx_hold_seen = 1'b0;
    int               gap_left = 0;
    int               stall_left = 0;
    int               rx_hold_len = 0;
    int               mismatches = 0;
    int               cycle_count = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_prime_by_division(input logic [VW-1:0] n);
        int unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [VW-1:0] pick_candidate();
        int unsigned r;
        int unsigned p;
        r = $urandom_range(0, 99);
        if (r < 60) return VW'($urandom_range(0, 1023));
        if (r < 75) return VW'($urandom_range(0, 65535));
        if (r < 85) begin
            p = $urandom_range(2, 255);
            return VW'(p * p);
        end
        if (r < 92) return VW'($urandom_range(2, 255) * $urandom_range(2, 255));
        return VW'($urandom_range(0, 2047) * 2 + 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic wait_for_drain();
        while (cand_queue.size() > 0 || s_tvalid || verdict_queue.size() > 0)
            @(posedge i_clk);
    endtask

    // Sender: holds a request until it is taken, with random gaps between requests unless calm is set.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (s_tvalid && !req_taken) begin
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (cand_queue.size() > 0 && (calm || $urandom_range(0, 7) != 0)) begin
            s_tvalid <= 1'b1;
            s_tdata  <= IN_W'(cand_queue.pop_front());
        end else begin
            s_tvalid <= 1'b0;
            if (cand_queue.size() > 0 && !calm) gap_left = $urandom_range(0, 9);
        end
    end

    // Long receiver hold: a toggle of rx_hold_req starts the rx_hold_len countdown.
    always @(negedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_len  <= RX_HOLD_CYCLES;
        end else if (rx_hold_len > 0) begin
            rx_hold_len <= rx_hold_len - 1;
        end
    end

    // Receiver: random stall bursts unless calm is set, plus the long hold when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (rx_hold_len > 0) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && o_s_tready;
            if (s_tvalid && o_s_tready)
                verdict_queue.push_back('{value: s_tdata[VW-1:0],
                                          prime: is_prime_by_division(s_tdata[VW-1:0])});
            if (o_m_tvalid && m_tready) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result with no request pending", 32'(o_m_tdata), 32'd0);
                end else begin
                    oldest = verdict_queue.pop_front();
                    if (o_m_tdata[VW-1:0] !== oldest.value)
                        report_mismatch("tested_value", 32'(o_m_tdata[VW-1:0]),
                                        32'(oldest.value));
                    if (o_m_tdata[VW] !== oldest.prime)
                        report_mismatch("is_prime", 32'(o_m_tdata[VW]), 32'(oldest.prime));
                    if (o_m_tdata[OUT_W-1:VW+1] !== '0)
                        report_mismatch("padding", 32'(o_m_tdata[OUT_W-1:VW+1]), 32'd0);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Small candidates, squares of primes, the largest prime and square, bit patterns.
        cand_queue = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 121, 169, 221, 255, 256, 257,
                       32767, 32768, 21845, 43690, 65534, 65535, 63001, 65521};
        wait_for_drain();

        // Keep the receiver off while requests pile up against the block.
        @(posedge i_clk);
        rx_hold_req = ~rx_hold_req;
        repeat (20) cand_queue.push_back(VW'($urandom_range(0, 255)));
        wait_for_drain();

        repeat (460) cand_queue.push_back(pick_candidate());
        while (cand_queue.size() > 0) @(posedge i_clk);
        calm = 1'b1;
        repeat (100) cand_queue.push_back(pick_candidate());
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_rem_unit.sv
rtl/core/trial_division_prime_test.sv
dv/tb_trial_division_prime_test.sv
